@@ rtl/core/kcs_pkg.sv @@
`timescale 1ns / 1ps
// Keyframe channel sampler package: sizes, codes, sequencer states and
// the structs passed between the sampler modules. No dependencies.
package kcs_pkg;

    // Storage geometry
    localparam int CHANNEL_COUNT = 64;
    localparam int MAX_KEYS      = 64;
    localparam int STORE_DEPTH   = CHANNEL_COUNT * MAX_KEYS;
    localparam int CH_AW         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int KEY_AW        = $clog2(MAX_KEYS);
    localparam int CNT_W         = KEY_AW + 1;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    // Fraction divider: one quotient bit per step
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    // Item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_CLAMP  = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [31:0] AMOUNT_MIN = 32'h8000_0000;
    localparam logic [31:0] AMOUNT_MAX = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_CHAN,
        S_CHK,
        S_ZERO,
        S_SCAN,
        S_RDA,
        S_DIV,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       frame;
        logic [31:0]       amount;
    } t_key_wr;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

endpackage

@@ rtl/core/kcs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sampler input and result items.
// Standalone; payload widths are fixed by the item formats.
interface kcs_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [5:0]  channel;
    logic [5:0]  key_slot;
    logic [15:0] key_frame;
    logic [31:0] key_amount;
    logic        negate_value;
    logic [31:0] query_time;

    modport source (output valid, func, channel, key_slot, key_frame, key_amount,
                    negate_value, query_time, input ready);
    modport sink   (input valid, func, channel, key_slot, key_frame, key_amount,
                    negate_value, query_time, output ready);
endinterface

interface kcs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sampled_value;
    logic [1:0]  sample_status;
    logic [5:0]  base_key;

    modport source (output valid, sampled_value, sample_status, base_key, input ready);
    modport sink   (input valid, sampled_value, sample_status, base_key, output ready);
endinterface

@@ rtl/core/keyframe_channel_sampler_unit.sv @@
`timescale 1ns / 1ps
// Keyframe channel sampler top level: sequencer, channel count and cursor
// memories, shared divider and multiply. Depends on kcs_pkg, kcs_if,
// kcs_key_store and kcs_divider.
//
//  port   | dir | transfer carries
//  i_in   | in  | load key (func 0) or sample request (func 1)
//  o_out  | out | sampled value, status, base key (one per sample)
//
// A load passes through S_LOAD. An interpolated sample runs S_CHAN, S_CHK, S_SCAN,
// S_RDA, S_DIV (32-step fraction divider), S_MUL, S_FIN and S_OUT; an empty
// channel goes from S_CHK to S_OUT, time zero via S_ZERO, other clamps from S_SCAN.
// Each key scanned further adds a scan step, as does a stale cursor's restart at key 0.
// No clearing pass after reset: counts and cursors use valid bits.
// A full output register stalls the sequencer at its last step only.
module keyframe_channel_sampler_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcs_in_if.sink    i_in,
    kcs_out_if.source o_out
);
    import kcs_pkg::*;

    t_state r_state, n_state;

    // captured item
    logic              r_func, n_func;
    logic [CH_AW-1:0]  r_ch, n_ch;
    logic              r_chok, n_chok;
    logic              r_slotok, n_slotok;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [KEY_AW-1:0] r_kidx, n_kidx;
    logic [15:0]       r_frame, n_frame;
    logic [31:0]       r_amount, n_amount;
    logic [31:0]       r_t, n_t;

    // search and arithmetic state
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_first, n_first;
    logic [KEY_AW-1:0] r_bkey, n_bkey;
    logic              r_upd, n_upd;
    logic [31:0]       r_a, n_a;
    logic [31:0]       r_b, n_b;
    logic [31:0]       r_tc, n_tc;
    logic [31:0]       r_q, n_q;
    logic [31:0]       r_off, n_off;
    logic [31:0]       r_res, n_res;
    logic [1:0]        r_stat, n_stat;

    // output register
    logic        r_ovld;
    logic [31:0] r_oval;
    logic [1:0]  r_ostat;
    logic [5:0]  r_okey;

    // channel count and cursor memories with reset valid bits
    logic [CNT_W-1:0]         r_cnt_mem [CHANNEL_COUNT];
    logic [KEY_AW-1:0]        r_cur_mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] r_cnt_vld;
    logic [CHANNEL_COUNT-1:0] r_cur_vld;
    logic [CNT_W-1:0]         r_cnt_rd;
    logic [KEY_AW-1:0]        r_cur_rd;
    logic                     r_cnt_rv;
    logic                     r_cur_rv;

    logic              w_accept;
    logic              w_out_free;
    logic              w_cnt_we;
    logic              w_cur_we;
    t_key_wr           w_key_wr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [15:0]       w_rd_frame;
    logic [31:0]       w_rd_amount;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_cur;
    logic [CNT_W-1:0]  w_start;
    logic [31:0]       w_tk;
    logic              w_le;
    logic [CNT_W-1:0]  w_nidx;
    logic              w_restart;
    logic [32:0]       w_diff;
    logic [31:0]       w_mag;
    logic [63:0]       w_prod;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovld || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // search conditions
    assign w_cnt     = (r_chok && r_cnt_rv) ? r_cnt_rd : '0;
    assign w_cur     = r_cur_rv ? CNT_W'(r_cur_rd) : '0;
    assign w_start   = (w_cur < w_cnt) ? w_cur : '0;
    assign w_tk      = {w_rd_frame, 16'h0000};
    assign w_le      = (w_tk <= r_t);
    assign w_nidx    = r_idx + 1'b1;
    assign w_restart = r_first && (r_idx != '0) && !w_le;

    // magnitude of the key step and its scaled offset
    assign w_diff = {r_b[31], r_b} - {r_a[31], r_a};
    assign w_mag  = w_diff[32] ? 32'(-w_diff) : w_diff[31:0];
    assign w_prod = {32'h0, w_mag} * {32'h0, r_q};

    kcs_key_store u_key_store (
        .i_clk       (i_clk),
        .i_wr        (w_key_wr),
        .i_rd_addr   (w_rd_addr),
        .o_rd_frame  (w_rd_frame),
        .o_rd_amount (w_rd_amount)
    );

    kcs_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.func == FUNC_LOAD) ? S_LOAD : S_CHAN;
                end
            end
            S_LOAD: n_state = S_IDLE;
            S_CHAN: n_state = S_CHK;
            S_CHK: begin
                if (w_cnt == '0) begin
                    n_state = S_OUT;
                end else if (r_t == '0) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ZERO: n_state = S_OUT;
            S_SCAN: begin
                if (w_restart) begin
                    n_state = S_SCAN;
                end else if (w_le) begin
                    n_state = (w_nidx == r_cnt) ? S_OUT : S_SCAN;
                end else begin
                    n_state = (r_idx == '0) ? S_OUT : S_RDA;
                end
            end
            S_RDA: n_state = S_DIV;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_FIN;
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_func   = r_func;
        n_ch     = r_ch;
        n_chok   = r_chok;
        n_slotok = r_slotok;
        n_base   = r_base;
        n_kidx   = r_kidx;
        n_frame  = r_frame;
        n_amount = r_amount;
        n_t      = r_t;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_first  = r_first;
        n_bkey   = r_bkey;
        n_upd    = r_upd;
        n_a      = r_a;
        n_b      = r_b;
        n_tc     = r_tc;
        n_q      = r_q;
        n_off    = r_off;
        n_res    = r_res;
        n_stat   = r_stat;

        w_key_wr        = '0;
        w_key_wr.addr   = r_base + ADDR_W'(r_kidx);
        w_key_wr.frame  = r_frame;
        w_key_wr.amount = r_amount;
        w_rd_addr       = r_base + ADDR_W'(r_idx);
        w_div_req       = '0;
        w_cnt_we        = 1'b0;
        w_cur_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func   = i_in.func;
                    n_ch     = CH_AW'(i_in.channel);
                    n_chok   = (32'(i_in.channel) < CHANNEL_COUNT);
                    n_slotok = (32'(i_in.key_slot) < MAX_KEYS);
                    n_base   = ADDR_W'(CH_AW'(i_in.channel)) * ADDR_W'(MAX_KEYS);
                    n_kidx   = KEY_AW'(i_in.key_slot);
                    n_frame  = i_in.key_frame;
                    n_t      = i_in.query_time;
                    if (!i_in.negate_value) begin
                        n_amount = i_in.key_amount;
                    end else if (i_in.key_amount == AMOUNT_MIN) begin
                        n_amount = AMOUNT_MAX;
                    end else begin
                        n_amount = 32'(-i_in.key_amount);
                    end
                end
            end
            S_LOAD: begin
                w_key_wr.en = r_chok && r_slotok;
                w_cnt_we    = r_chok && r_slotok;
            end
            S_CHK: begin
                n_cnt   = w_cnt;
                n_first = 1'b1;
                n_upd   = 1'b0;
                n_bkey  = '0;
                if (w_cnt == '0) begin
                    n_res  = '0;
                    n_stat = ST_EMPTY;
                    n_idx  = '0;
                end else if (r_t == '0) begin
                    n_idx = '0;
                end else begin
                    n_idx = w_start;
                end
                w_rd_addr = r_base + ADDR_W'(n_idx);
            end
            S_ZERO: begin
                n_res  = w_rd_amount;
                n_stat = ST_CLAMP;
            end
            S_SCAN: begin
                n_first = 1'b0;
                if (w_restart) begin
                    n_idx = '0;
                end else if (w_le) begin
                    if (w_nidx == r_cnt) begin
                        n_bkey = KEY_AW'(r_idx);
                        n_res  = w_rd_amount;
                        n_stat = ST_CLAMP;
                        n_upd  = 1'b1;
                    end else begin
                        n_idx = w_nidx;
                    end
                end else if (r_idx == '0) begin
                    n_bkey = '0;
                    n_res  = w_rd_amount;
                    n_stat = ST_CLAMP;
                    n_upd  = 1'b1;
                end else begin
                    n_b    = w_rd_amount;
                    n_tc   = w_tk;
                    n_idx  = r_idx - 1'b1;
                    n_bkey = KEY_AW'(r_idx - 1'b1);
                    n_upd  = 1'b1;
                end
                w_rd_addr = r_base + ADDR_W'(n_idx);
            end
            S_RDA: begin
                // previous key is on the read port: launch the fraction
                n_a             = w_rd_amount;
                w_div_req.start = 1'b1;
                w_div_req.num   = r_t - {w_rd_frame, 16'h0000};
                w_div_req.den   = r_tc - {w_rd_frame, 16'h0000};
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_q = w_div_rsp.quo;
                end
            end
            S_MUL: begin
                n_off = w_prod[63:32];
            end
            S_FIN: begin
                n_res  = w_diff[32] ? (r_a - r_off) : (r_a + r_off);
                n_stat = ST_INTERP;
            end
            S_OUT: begin
                w_cur_we = w_out_free && r_upd;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovld    <= 1'b0;
            r_cnt_vld <= '0;
            r_cur_vld <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
            if (w_cnt_we) begin
                r_cnt_vld[r_ch] <= 1'b1;
            end
            if (w_cur_we) begin
                r_cur_vld[r_ch] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_ch     <= n_ch;
        r_chok   <= n_chok;
        r_slotok <= n_slotok;
        r_base   <= n_base;
        r_kidx   <= n_kidx;
        r_frame  <= n_frame;
        r_amount <= n_amount;
        r_t      <= n_t;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_first  <= n_first;
        r_bkey   <= n_bkey;
        r_upd    <= n_upd;
        r_a      <= n_a;
        r_b      <= n_b;
        r_tc     <= n_tc;
        r_q      <= n_q;
        r_off    <= n_off;
        r_res    <= n_res;
        r_stat   <= n_stat;
        if (r_state == S_OUT && w_out_free) begin
            r_oval  <= r_res;
            r_ostat <= r_stat;
            r_okey  <= 6'(r_bkey);
        end
    end

    // count and cursor memories
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[r_ch] <= CNT_W'(r_kidx) + 1'b1;
        end
        if (w_cur_we) begin
            r_cur_mem[r_ch] <= r_bkey;
        end
        r_cnt_rd <= r_cnt_mem[r_ch];
        r_cur_rd <= r_cur_mem[r_ch];
        r_cnt_rv <= r_cnt_vld[r_ch];
        r_cur_rv <= r_cur_vld[r_ch];
    end

    assign o_out.valid         = r_ovld;
    assign o_out.sampled_value = r_oval;
    assign o_out.sample_status = r_ostat;
    assign o_out.base_key      = r_okey;
endmodule

@@ rtl/core/kcs_key_store.sv @@
`timescale 1ns / 1ps
// Key memory: frame time and Q16.16 value per key, one write and one
// registered read per cycle. Depends on kcs_pkg.
module kcs_key_store (
    input  logic                       i_clk,
    input  kcs_pkg::t_key_wr           i_wr,
    input  logic [kcs_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [15:0]                o_rd_frame,
    output logic [31:0]                o_rd_amount
);
    import kcs_pkg::*;

    logic [15:0] r_frame_mem  [STORE_DEPTH];
    logic [31:0] r_amount_mem [STORE_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_frame_mem[i_wr.addr]  <= i_wr.frame;
            r_amount_mem[i_wr.addr] <= i_wr.amount;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_frame  <= r_frame_mem[i_rd_addr];
        o_rd_amount <= r_amount_mem[i_rd_addr];
    end
endmodule

@@ rtl/core/kcs_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider for the interpolation fraction: (num << 32) / den with
// num < den, one quotient bit per cycle. Depends on kcs_pkg.
module kcs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kcs_pkg::t_div_req i_req,
    output kcs_pkg::t_div_rsp o_rsp
);
    import kcs_pkg::*;

    logic              r_busy, n_busy;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [32:0]       r_rem, n_rem;
    logic [31:0]       r_den, n_den;
    logic [31:0]       r_quo, n_quo;
    logic [32:0]       w_sh;
    logic              w_ge;

    assign w_sh = {r_rem[31:0], 1'b0};
    assign w_ge = (w_sh >= {1'b0, r_den});

    // one shift/subtract step per cycle
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CW'(DIV_STEPS);
            n_rem  = {1'b0, i_req.num};
            n_den  = i_req.den;
            n_quo  = '0;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_rem = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
                n_quo = {r_quo[30:0], w_ge};
                n_cnt = r_cnt - 1'b1;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quo  = r_quo;
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for keyframe_channel_sampler_unit: directed and random key loads and
// channel samples checked against a behavioral sampler model.
// Depends on kcs_pkg, kcs_if and the sampler RTL.
module testbench;
    import kcs_pkg::*;

    typedef struct packed {
        logic        func;
        logic [5:0]  channel;
        logic [5:0]  key_slot;
        logic [15:0] key_frame;
        logic [31:0] key_amount;
        logic        negate_value;
        logic [31:0] query_time;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic [5:0]  bkey;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kcs_in_if  in_ch ();
    kcs_out_if out_ch ();

    keyframe_channel_sampler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state
    logic [15:0] key_frames  [0:STORE_DEPTH-1];
    logic [31:0] key_amounts [0:STORE_DEPTH-1];
    logic [6:0]  key_count   [0:CHANNEL_COUNT-1];
    logic [5:0]  cursor      [0:CHANNEL_COUNT-1];
    logic [15:0] last_frame  [0:CHANNEL_COUNT-1];

    t_item   pending_items[$];
    t_sample expected_samples[$];
    int      mismatches = 0;
    int      samples_seen = 0;
    int      loads_sent = 0;
    bit      stim_done = 1'b0;

    // Linear interpolation: a + sign(b-a) * floor(|b-a| * f / 2^32)
    function automatic logic [31:0] lerp_amount(logic [31:0] a_bits, logic [31:0] b_bits,
                                                logic [63:0] num, logic [63:0] den);
        longint      a, b, d, r;
        logic [63:0] mag, f, off;
        logic [127:0] prod;
        a = longint'($signed(a_bits));
        b = longint'($signed(b_bits));
        d = b - a;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        f = (num << 32) / den;
        prod = 128'(mag) * 128'(f);
        off = prod[95:32];
        r = (d < 0) ? a - longint'(off) : a + longint'(off);
        return r[31:0];
    endfunction

    // Apply one accepted item to the model; push a result for samples
    task automatic apply_item(input t_item it);
        int          base, cnt, i, start;
        logic [31:0] amt;
        logic [63:0] t, tp, tc;
        t_sample     s;
        base = int'(it.channel) * MAX_KEYS;
        if (it.func == FUNC_LOAD) begin
            amt = it.key_amount;
            if (it.negate_value)
                amt = (amt == AMOUNT_MIN) ? AMOUNT_MAX : 32'(0 - amt);
            key_frames[base + it.key_slot]  = it.key_frame;
            key_amounts[base + it.key_slot] = amt;
            key_count[it.channel] = 7'(it.key_slot) + 7'd1;
            return;
        end
        s.value = '0; s.status = ST_EMPTY; s.bkey = '0;
        cnt = key_count[it.channel];
        t = 64'(it.query_time);
        if (cnt != 0) begin
            if (t == 0) begin
                s.value = key_amounts[base];
                s.status = ST_CLAMP;
            end else begin
                start = cursor[it.channel];
                if (start >= cnt || (64'(key_frames[base + start]) << 16) > t)
                    start = 0;
                i = start;
                while (i < cnt && (64'(key_frames[base + i]) << 16) <= t)
                    i++;
                if (i == cnt) begin
                    s.bkey = 6'(cnt - 1);
                    s.value = key_amounts[base + cnt - 1];
                    s.status = ST_CLAMP;
                end else if (i == 0) begin
                    s.value = key_amounts[base];
                    s.status = ST_CLAMP;
                end else begin
                    tp = 64'(key_frames[base + i - 1]) << 16;
                    tc = 64'(key_frames[base + i]) << 16;
                    s.bkey = 6'(i - 1);
                    s.value = lerp_amount(key_amounts[base + i - 1], key_amounts[base + i],
                                          t - tp, tc - tp);
                    s.status = ST_INTERP;
                end
                cursor[it.channel] = s.bkey;
            end
        end
        expected_samples.push_back(s);
    endtask

    // Driver: pops pending items, random gap after each
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the current transfer
        end else begin
            if (in_ch.valid)
                apply_item(t_item'({in_ch.func, in_ch.channel, in_ch.key_slot,
                    in_ch.key_frame, in_ch.key_amount, in_ch.negate_value,
                    in_ch.query_time}));
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                t_item it;
                it = pending_items.pop_front();
                {in_ch.func, in_ch.channel, in_ch.key_slot, in_ch.key_frame,
                 in_ch.key_amount, in_ch.negate_value, in_ch.query_time} <= it;
                in_ch.valid <= 1'b1;
                in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer, random stalls on ready
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_sample got, exp_s;
                got = {out_ch.sampled_value, out_ch.sample_status, out_ch.base_key};
                samples_seen++;
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected sample result %h/%0d/%0d",
                                 got.value, got.status, got.bkey);
                end else begin
                    exp_s = expected_samples.pop_front();
                    if (got !== exp_s) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     exp_s.value, exp_s.status, exp_s.bkey,
                                     got.value, got.status, got.bkey);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (out_ch.valid && out_ch.ready)
                    out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
        end
    end

    // Stimulus helpers
    function automatic t_item load_item(logic [5:0] ch, logic [5:0] slot, logic [15:0] fr,
                                        logic [31:0] amt, logic neg);
        t_item it;
        it = '0;
        it.func = FUNC_LOAD; it.channel = ch; it.key_slot = slot;
        it.key_frame = fr; it.key_amount = amt; it.negate_value = neg;
        it.query_time = $urandom;
        return it;
    endfunction

    function automatic t_item sample_item(logic [5:0] ch, logic [31:0] t);
        t_item it;
        it = '0;
        it.func = FUNC_SAMPLE; it.channel = ch; it.query_time = t;
        it.key_slot = 6'($urandom); it.key_frame = 16'($urandom);
        it.key_amount = $urandom;
        it.negate_value = 1'($urandom);
        return it;
    endfunction

    // Keys of the latest build per channel, only counts keys built in ascending order
    int built [0:CHANNEL_COUNT-1];

    // Append a fresh ascending key set for one channel
    task automatic build_channel(int ch, int nkeys, bit wide);
        int          fr, k;
        logic [31:0] amt;
        fr = $urandom_range(0, 20);
        for (k = 0; k < nkeys; k++) begin
            amt = wide ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
            pending_items.push_back(load_item(6'(ch), 6'(k), 16'(fr), amt, 1'($urandom)));
            last_frame[ch] = 16'(fr);
            fr += $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, wide ? 3000 : 30);
            if (fr > 65535) fr = 65535;
            loads_sent++;
        end
        built[ch] = nkeys;
    endtask

    initial begin
        int n, ch, c;
        logic [31:0] t;
        in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.channel = '0; in_ch.key_slot = '0;
        in_ch.key_frame = '0; in_ch.key_amount = '0; in_ch.negate_value = 1'b0;
        in_ch.query_time = '0;
        out_ch.ready = 1'b0;
        for (c = 0; c < CHANNEL_COUNT; c++) begin
            key_count[c] = '0; cursor[c] = '0; built[c] = 0; last_frame[c] = '0;
        end

        // Directed: empty channel, extremes, negation saturation, clamps
        pending_items.push_back(sample_item(6'd63, 32'hFFFF_FFFF));
        pending_items.push_back(load_item(6'd63, 6'd0, 16'd10, AMOUNT_MIN, 1'b1));
        pending_items.push_back(load_item(6'd63, 6'd1, 16'd20, AMOUNT_MIN, 1'b0));
        pending_items.push_back(load_item(6'd63, 6'd2, 16'hFFFF, AMOUNT_MAX, 1'b0));
        pending_items.push_back(sample_item(6'd63, 32'd0));
        pending_items.push_back(sample_item(6'd63, 32'd1));
        pending_items.push_back(sample_item(6'd63, 32'h000F_8000));
        pending_items.push_back(sample_item(6'd63, 32'h000A_0000));
        pending_items.push_back(sample_item(6'd63, 32'h0013_FFFF));
        pending_items.push_back(sample_item(6'd63, 32'h0014_0001));
        pending_items.push_back(sample_item(6'd63, 32'hFFFE_FFFF));
        pending_items.push_back(sample_item(6'd63, 32'hFFFF_FFFF));
        pending_items.push_back(sample_item(6'd63, 32'h0000_0001));
        // Shrink channel to a single key
        pending_items.push_back(load_item(6'd63, 6'd0, 16'd5, 32'h0001_0000, 1'b0));
        pending_items.push_back(sample_item(6'd63, 32'h0100_0000));
        // Full-depth channel, slot 63
        pending_items.push_back(load_item(6'd0, 6'd0, 16'd0, 32'hFFFF_0000, 1'b1));
        pending_items.push_back(load_item(6'd0, 6'd63, 16'd100, 32'h0000_0001, 1'b0));
        key_count[0] = '0;
        // Slot 63 read without slots 1..62 written is avoided: rewrite as ascending set
        build_channel(0, 64, 1'b0);
        build_channel(63, 3, 1'b1);

        // Random: mostly samples on built channels, some rebuilds
        n = 0;
        while (n < 400) begin
            ch = $urandom_range(0, CHANNEL_COUNT - 1);
            if (built[ch] == 0 || $urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_items.push_back(sample_item(6'(ch), $urandom));
                    if (built[ch] == 0) n++;
                end else begin
                    c = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                                     : $urandom_range(1, 6);
                    build_channel(ch, c, 1'($urandom_range(0, 1)));
                    n += c;
                    continue;
                end
                if (built[ch] == 0) continue;
            end
            case ($urandom_range(0, 5))
                0: t = $urandom;
                1: t = (32'(last_frame[ch]) << 16) + $urandom_range(0, 3);
                2: t = $urandom_range(0, 3);
                default: t = 32'($urandom_range(0, 32'(last_frame[ch]) + 2)) << 16
                             | 32'($urandom_range(0, 65535));
            endcase
            pending_items.push_back(sample_item(6'(ch), t));
            n++;
        end
        for (c = 0; c < CHANNEL_COUNT; c++) key_count[c] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (in_ch.valid) @(posedge i_clk);
        stim_done = 1'b1;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d key loads and %0d sample results over 64 channels.",
                 loads_sent, samples_seen);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule

@@ keyframe_channel_sampler_unit.f @@
rtl/core/kcs_pkg.sv
rtl/core/kcs_if.sv
rtl/core/kcs_key_store.sv
rtl/core/kcs_divider.sv
rtl/core/keyframe_channel_sampler_unit.sv
tb/sv/testbench.sv
